[rtl/core/sbt_pkg.sv]
// shared types, token kind codes and character classes for the source byte tokenizer
package sbt_pkg;

  localparam int unsigned PositionBitsDefault = 32;
  localparam int unsigned DepthBitsDefault    = 16;
  localparam int unsigned KeywordBytesDefault = 14;
  localparam int unsigned KwCount             = 30;
  localparam int unsigned KwMaxLen            = 14;

  localparam logic [6:0] K_EOF      = 7'd0;
  localparam logic [6:0] K_INVALID  = 7'd1;
  localparam logic [6:0] K_SPACE    = 7'd2;
  localparam logic [6:0] K_NEWLINE  = 7'd3;
  localparam logic [6:0] K_LINE     = 7'd4;
  localparam logic [6:0] K_BLOCK    = 7'd5;
  localparam logic [6:0] K_IDENT    = 7'd6;
  localparam logic [6:0] K_INT      = 7'd7;
  localparam logic [6:0] K_STRING   = 7'd8;
  localparam logic [6:0] K_KEY0     = 7'd9;
  localparam logic [6:0] K_LPAREN   = 7'd39;
  localparam logic [6:0] K_RPAREN   = 7'd40;
  localparam logic [6:0] K_LBRACE   = 7'd41;
  localparam logic [6:0] K_RBRACE   = 7'd42;
  localparam logic [6:0] K_LBRACK   = 7'd43;
  localparam logic [6:0] K_RBRACK   = 7'd44;
  localparam logic [6:0] K_LT       = 7'd45;
  localparam logic [6:0] K_GT       = 7'd46;
  localparam logic [6:0] K_LE       = 7'd47;
  localparam logic [6:0] K_GE       = 7'd48;
  localparam logic [6:0] K_ASSIGN   = 7'd49;
  localparam logic [6:0] K_EQ       = 7'd50;
  localparam logic [6:0] K_BANG     = 7'd51;
  localparam logic [6:0] K_NE       = 7'd52;
  localparam logic [6:0] K_PLUS     = 7'd53;
  localparam logic [6:0] K_MINUS    = 7'd54;
  localparam logic [6:0] K_STAR     = 7'd55;
  localparam logic [6:0] K_SLASH    = 7'd56;
  localparam logic [6:0] K_PERCENT  = 7'd57;
  localparam logic [6:0] K_ANDAND   = 7'd58;
  localparam logic [6:0] K_OROR     = 7'd59;
  localparam logic [6:0] K_DOT      = 7'd60;
  localparam logic [6:0] K_COMMA    = 7'd61;
  localparam logic [6:0] K_COLON    = 7'd62;
  localparam logic [6:0] K_AT       = 7'd63;
  localparam logic [6:0] K_QUEST    = 7'd64;
  localparam logic [6:0] K_ARROW    = 7'd65;
  localparam logic [6:0] K_FATARROW = 7'd66;

  localparam logic [1:0] E_NONE     = 2'd0;
  localparam logic [1:0] E_INVALID  = 2'd1;
  localparam logic [1:0] E_STRING   = 2'd2;
  localparam logic [1:0] E_BLOCK    = 2'd3;

  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_UNDER   = 8'h5F;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_NONE    = 8'h00;

  typedef enum logic [3:0] {
    LEX_IDLE, LEX_SPACE, LEX_CR, LEX_IDENT, LEX_INT,
    LEX_STRING, LEX_SLASH, LEX_LINE, LEX_BLOCK, LEX_OP
  } lex_mode_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_source;
  } in_word_t;

  typedef struct packed {
    logic [6:0]  token_kind;
    logic [31:0] span_start;
    logic [31:0] span_end;
    logic [1:0]  error_code;
    logic        last_of_run;
  } tok_word_t;

  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic [111:0] kw_text(input int unsigned k);
    logic [111:0] t;
    unique case (k)
      0: t = "module";        1: t = "edition";       2: t = "use";
      3: t = "public";        4: t = "private";       5: t = "record";
      6: t = "enum";          7: t = "type";          8: t = "distinct";
      9: t = "refined";       10: t = "where";        11: t = "open";
      12: t = "capability";   13: t = "trait";        14: t = "implementation";
      15: t = "for";          16: t = "function";     17: t = "effects";
      18: t = "requires";     19: t = "ensures";      20: t = "pure";
      21: t = "let";          22: t = "return";       23: t = "if";
      24: t = "else";         25: t = "match";        26: t = "handle";
      27: t = "with";         28: t = "true";         29: t = "false";
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic logic [4:0] kw_len(input int unsigned k);
    logic [4:0] n;
    unique case (k)
      0: n = 5'd6;   1: n = 5'd7;   2: n = 5'd3;   3: n = 5'd6;   4: n = 5'd7;
      5: n = 5'd6;   6: n = 5'd4;   7: n = 5'd4;   8: n = 5'd8;   9: n = 5'd7;
      10: n = 5'd5;  11: n = 5'd4;  12: n = 5'd10; 13: n = 5'd5;  14: n = 5'd14;
      15: n = 5'd3;  16: n = 5'd8;  17: n = 5'd7;  18: n = 5'd8;  19: n = 5'd7;
      20: n = 5'd4;  21: n = 5'd3;  22: n = 5'd6;  23: n = 5'd2;  24: n = 5'd4;
      25: n = 5'd5;  26: n = 5'd6;  27: n = 5'd4;  28: n = 5'd4;  29: n = 5'd5;
      default: n = 5'd0;
    endcase
    return n;
  endfunction

  // all keywords are compared in parallel against the buffered word
  function automatic logic [6:0] kw_kind(input logic [KwMaxLen-1:0][7:0] w,
                                         input logic [4:0] len);
    logic [6:0]   kind;
    logic         hit;
    logic [111:0] t;
    logic [4:0]   n;
    int           sel;
    kind = K_IDENT;
    for (int k = 0; k < KwCount; k++) begin
      t   = kw_text(k);
      n   = kw_len(k);
      hit = (n == len);
      for (int i = 0; i < KwMaxLen; i++) begin
        if (i < int'(n)) begin
          sel = (int'(n) - 1 - i) * 8;
          if (w[i] != t[sel +: 8]) hit = 1'b0;
        end
      end
      if (hit) kind = K_KEY0 + 7'(k);
    end
    return kind;
  endfunction

  function automatic logic [6:0] single_kind(input logic [7:0] b);
    logic [6:0] k;
    unique case (b)
      "(": k = K_LPAREN;   ")": k = K_RPAREN;  "{": k = K_LBRACE;
      "}": k = K_RBRACE;   "[": k = K_LBRACK;  "]": k = K_RBRACK;
      "+": k = K_PLUS;     "*": k = K_STAR;    "%": k = K_PERCENT;
      ".": k = K_DOT;      ",": k = K_COMMA;   ":": k = K_COLON;
      "@": k = K_AT;       "?": k = K_QUEST;
      default: k = K_EOF;
    endcase
    return k;
  endfunction

  function automatic logic is_op_lead(input logic [7:0] b);
    return b == "-" || b == "=" || b == "!" || b == "<" || b == ">" || b == "&" || b == "|";
  endfunction

  function automatic logic [6:0] op_alone(input logic [7:0] p);
    logic [6:0] k;
    unique case (p)
      "-": k = K_MINUS;  "=": k = K_ASSIGN;  "!": k = K_BANG;
      "<": k = K_LT;     ">": k = K_GT;
      default: k = K_INVALID;
    endcase
    return k;
  endfunction

  function automatic logic [6:0] op_pair(input logic [7:0] p, input logic [7:0] b);
    logic [6:0] k;
    k = K_EOF;
    if (p == "-" && b == ">") k = K_ARROW;
    if (p == "=" && b == "=") k = K_EQ;
    if (p == "=" && b == ">") k = K_FATARROW;
    if (p == "!" && b == "=") k = K_NE;
    if (p == "<" && b == "=") k = K_LE;
    if (p == ">" && b == "=") k = K_GE;
    if (p == "&" && b == "&") k = K_ANDAND;
    if (p == "|" && b == "|") k = K_OROR;
    return k;
  endfunction

endpackage

[rtl/core/sbt_lexer.sv]
// lexer state registers and the combinational next-state and token logic
module sbt_lexer #(
  parameter int unsigned POSITION_BITS = sbt_pkg::PositionBitsDefault,
  parameter int unsigned DEPTH_BITS    = sbt_pkg::DepthBitsDefault,
  parameter int unsigned KEYWORD_BYTES = sbt_pkg::KeywordBytesDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  sbt_pkg::in_word_t item_i,
  output logic [1:0]        tok_count_o,
  output sbt_pkg::tok_word_t tok0_o,
  output sbt_pkg::tok_word_t tok1_o
);
  import sbt_pkg::*;

  localparam int unsigned PB = POSITION_BITS;
  localparam int unsigned DB = DEPTH_BITS;
  localparam int unsigned LW = $clog2(KEYWORD_BYTES + 1);
  localparam int unsigned IW = $clog2(KEYWORD_BYTES);

  lex_mode_e          mode_q, mode_d;
  logic [PB-1:0]      pos_q, pos_d, start_q, start_d;
  logic [7:0]         pend_q, pend_d;
  logic [DB-1:0]      depth_q, depth_d;
  logic [7:0]         wbuf_q [KEYWORD_BYTES];
  logic [LW-1:0]      wlen_q, wlen_d;
  logic               long_q, long_d, esc_q, esc_d;

  logic               wr_en;
  logic [IW-1:0]      wr_idx;
  logic [KwMaxLen-1:0][7:0] w14;
  logic [6:0]         wk, pk, ka, sk;
  logic [7:0]         b;
  logic [PB-1:0]      nxt, s1;
  logic               do_start;
  logic               a_v, b_v;
  logic [6:0]         a_kind, b_kind;
  logic [PB-1:0]      a_s, a_e, b_s, b_e;
  logic [1:0]         a_err, b_err;
  tok_word_t          ta, tb;

  always_comb begin
    for (int i = 0; i < KwMaxLen; i++) w14[i] = wbuf_q[i];
  end

  assign wk  = long_q ? K_IDENT : kw_kind(w14, 5'(wlen_q));
  assign b   = item_i.data_byte;
  assign nxt = pos_q + 1'b1;
  assign s1  = start_q + 1'b1;
  assign pk  = op_pair(pend_q, b);
  assign ka  = op_alone(pend_q);
  assign sk  = single_kind(b);

  always_comb begin
    mode_d = mode_q; pos_d = pos_q; start_d = start_q; pend_d = pend_q;
    depth_d = depth_q; wlen_d = wlen_q; long_d = long_q; esc_d = esc_q;
    wr_en = 1'b0; wr_idx = wlen_q[IW-1:0];
    do_start = 1'b0;
    a_v = 1'b0; a_kind = K_EOF; a_s = start_q; a_e = pos_q; a_err = E_NONE;
    b_v = 1'b0; b_kind = K_EOF; b_s = pos_q;   b_e = nxt;   b_err = E_NONE;

    if (step_i && item_i.end_of_source) begin
      // flush the open token, then eof, then back to the reset state
      a_v = 1'b1;
      unique case (mode_q)
        LEX_SPACE:  a_kind = K_SPACE;
        LEX_CR:     a_kind = K_NEWLINE;
        LEX_IDENT:  a_kind = wk;
        LEX_INT:    a_kind = K_INT;
        LEX_STRING: begin a_kind = K_STRING; a_err = E_STRING; end
        LEX_SLASH:  a_kind = K_SLASH;
        LEX_LINE:   a_kind = K_LINE;
        LEX_BLOCK:  begin a_kind = K_BLOCK; a_err = E_BLOCK; end
        LEX_OP: begin
          a_kind = ka;
          a_err  = (ka == K_INVALID) ? E_INVALID : E_NONE;
        end
        default:    a_v = 1'b0;
      endcase
      b_v = 1'b1; b_kind = K_EOF; b_s = pos_q; b_e = pos_q;
      mode_d = LEX_IDLE; pos_d = '0; start_d = '0; pend_d = CH_NONE;
      depth_d = '0; wlen_d = '0; long_d = 1'b0; esc_d = 1'b0;
    end else if (step_i) begin
      pos_d = nxt;
      unique case (mode_q)
        LEX_SPACE: begin
          if (!(b == CH_SPACE || b == CH_TAB)) begin
            a_v = 1'b1; a_kind = K_SPACE; do_start = 1'b1;
          end
        end
        LEX_CR: begin
          a_v = 1'b1; a_kind = K_NEWLINE;
          if (b == CH_LF) begin
            a_e = nxt; mode_d = LEX_IDLE;
          end else begin
            do_start = 1'b1;
          end
        end
        LEX_IDENT: begin
          if (b == CH_UNDER || is_alpha(b) || is_digit(b)) begin
            if (32'(wlen_q) < KEYWORD_BYTES) begin
              wr_en = 1'b1; wlen_d = wlen_q + 1'b1;
            end else begin
              long_d = 1'b1;
            end
          end else begin
            a_v = 1'b1; a_kind = wk; do_start = 1'b1;
          end
        end
        LEX_INT: begin
          if (!(is_digit(b) || b == CH_UNDER)) begin
            a_v = 1'b1; a_kind = K_INT; do_start = 1'b1;
          end
        end
        LEX_STRING: begin
          if (esc_q) begin
            esc_d = 1'b0;
          end else if (b == CH_QUOTE) begin
            a_v = 1'b1; a_kind = K_STRING; a_e = nxt; mode_d = LEX_IDLE;
          end else if (b == CH_LF || b == CH_CR) begin
            a_v = 1'b1; a_kind = K_STRING; a_err = E_STRING; do_start = 1'b1;
          end else if (b == CH_BSLASH) begin
            esc_d = 1'b1;
          end
        end
        LEX_SLASH: begin
          if (b == CH_SLASH) begin
            mode_d = LEX_LINE;
          end else if (b == CH_STAR) begin
            mode_d = LEX_BLOCK; depth_d = DB'(1); pend_d = CH_NONE;
          end else begin
            a_v = 1'b1; a_kind = K_SLASH; a_e = s1; do_start = 1'b1;
          end
        end
        LEX_LINE: begin
          if (b == CH_LF || b == CH_CR) begin
            a_v = 1'b1; a_kind = K_LINE; do_start = 1'b1;
          end
        end
        LEX_BLOCK: begin
          if (pend_q == CH_SLASH && b == CH_STAR) begin
            if (depth_q != '1) depth_d = depth_q + 1'b1;
            pend_d = CH_NONE;
          end else if (pend_q == CH_STAR && b == CH_SLASH) begin
            pend_d = CH_NONE;
            // closing pair: the comment ends once depth reaches zero
            if (depth_q <= DB'(1)) begin
              depth_d = '0;
              a_v = 1'b1; a_kind = K_BLOCK; a_e = nxt; mode_d = LEX_IDLE;
            end else begin
              depth_d = depth_q - 1'b1;
            end
          end else begin
            pend_d = (b == CH_SLASH || b == CH_STAR) ? b : CH_NONE;
          end
        end
        LEX_OP: begin
          a_v = 1'b1;
          if (pk != K_EOF) begin
            a_kind = pk; a_e = nxt; mode_d = LEX_IDLE;
          end else begin
            a_kind = ka; a_e = s1;
            a_err = (ka == K_INVALID) ? E_INVALID : E_NONE;
            do_start = 1'b1;
          end
        end
        default: do_start = 1'b1;
      endcase

      if (do_start) begin
        start_d = pos_q;
        mode_d  = LEX_IDLE;
        priority if (b == CH_SPACE || b == CH_TAB) begin
          mode_d = LEX_SPACE;
        end else if (b == CH_LF) begin
          b_v = 1'b1; b_kind = K_NEWLINE;
        end else if (b == CH_CR) begin
          mode_d = LEX_CR;
        end else if (b == CH_UNDER || is_alpha(b)) begin
          mode_d = LEX_IDENT; wr_en = 1'b1; wr_idx = '0;
          wlen_d = LW'(1); long_d = 1'b0;
        end else if (is_digit(b)) begin
          mode_d = LEX_INT;
        end else if (b == CH_QUOTE) begin
          mode_d = LEX_STRING; esc_d = 1'b0;
        end else if (b == CH_SLASH) begin
          mode_d = LEX_SLASH;
        end else if (sk != K_EOF) begin
          b_v = 1'b1; b_kind = sk;
        end else if (is_op_lead(b)) begin
          mode_d = LEX_OP; pend_d = b;
        end else begin
          b_v = 1'b1; b_kind = K_INVALID; b_err = E_INVALID;
        end
      end
    end
  end

  // offsets leave on 32 bits whatever the counter width
  always_comb begin
    logic [PB+31:0] xs, xe, ys, ye;
    xs = {32'd0, a_s}; xe = {32'd0, a_e}; ys = {32'd0, b_s}; ye = {32'd0, b_e};
    ta = '{token_kind: a_kind, span_start: xs[31:0], span_end: xe[31:0],
           error_code: a_err, last_of_run: !b_v};
    tb = '{token_kind: b_kind, span_start: ys[31:0], span_end: ye[31:0],
           error_code: b_err, last_of_run: 1'b1};
  end

  assign tok0_o      = a_v ? ta : tb;
  assign tok1_o      = tb;
  assign tok_count_o = {1'b0, a_v} + {1'b0, b_v};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= LEX_IDLE; pos_q <= '0; start_q <= '0; pend_q <= CH_NONE;
      depth_q <= '0; wlen_q <= '0; long_q <= 1'b0; esc_q <= 1'b0;
    end else begin
      mode_q <= mode_d; pos_q <= pos_d; start_q <= start_d; pend_q <= pend_d;
      depth_q <= depth_d; wlen_q <= wlen_d; long_q <= long_d; esc_q <= esc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) wbuf_q[wr_idx] <= b;
  end

endmodule

[rtl/core/sbt_out_fifo.sv]
// four-entry result queue taking up to two words a cycle
module sbt_out_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [1:0]         push_n_i,
  input  sbt_pkg::tok_word_t push0_i,
  input  sbt_pkg::tok_word_t push1_i,
  input  logic               pop_i,
  output logic               room_o,
  output logic [2:0]         count_o,
  output logic               valid_o,
  output sbt_pkg::tok_word_t head_o
);
  import sbt_pkg::*;

  tok_word_t  ent_q [4];
  logic [1:0] rd_q, rd_d, wr_q, wr_d;
  logic [2:0] cnt_q, cnt_d;
  logic       pop;

  assign pop     = pop_i && (cnt_q != 3'd0);
  assign rd_d    = rd_q + {1'b0, pop};
  assign wr_d    = wr_q + push_n_i;
  assign cnt_d   = cnt_q + {1'b0, push_n_i} - {2'b0, pop};
  assign room_o  = cnt_q <= 3'd2;
  assign count_o = cnt_q;
  assign valid_o = cnt_q != 3'd0;
  assign head_o  = ent_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= '0; wr_q <= '0; cnt_q <= '0;
    end else begin
      rd_q <= rd_d; wr_q <= wr_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) ent_q[wr_q] <= push0_i;
    if (push_n_i == 2'd2) ent_q[wr_q + 2'd1] <= push1_i;
  end

endmodule

[rtl/core/source_byte_tokenizer_top.sv]
// top level of the source byte tokenizer: input register, lexer, result queue
//
//  channel | direction | handshake         | word
//  --------+-----------+-------------------+------------------------------------
//  in      | sink      | valid_i / stall_o | in_word_t  {data_byte, end_of_source}
//  out     | source    | valid_o / stall_i | tok_word_t {kind, spans, error, last}
//
// one input word per cycle while the result queue has room for two tokens
// each word is held in the input register until the queue has room, the lexer works on
// it combinationally there and its tokens are registered into the result queue
// a word that ends one token and gives a one-byte token or eof pushes two results;
// with the output side stalled the queue passes two entries and stall_o rises
// reset clears lexer state, offsets, queue pointers and the input valid flag

module source_byte_tokenizer_top #(
  parameter int unsigned POSITION_BITS = sbt_pkg::PositionBitsDefault,
  parameter int unsigned DEPTH_BITS    = sbt_pkg::DepthBitsDefault,
  parameter int unsigned KEYWORD_BYTES = sbt_pkg::KeywordBytesDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  sbt_pkg::in_word_t  data_i,
  output logic               valid_o,
  input  logic               stall_i,
  output sbt_pkg::tok_word_t data_o
);
  import sbt_pkg::*;

  // input register
  logic      in_v_q, in_v_d;
  in_word_t  in_q;
  logic      accept;
  logic      step;

  // lexer results
  logic [1:0] tok_n;
  tok_word_t  tok0, tok1;

  // queue status
  logic       room;
  logic [2:0] count;

  // the lexer fires when it holds a word and the queue can take two more
  assign step    = in_v_q && room;
  assign stall_o = in_v_q && !room;
  assign accept  = valid_i && !stall_o;
  assign in_v_d  = accept || (in_v_q && !step);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else begin
      in_v_q <= in_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) in_q <= data_i;
  end

  sbt_lexer #(
    .POSITION_BITS (POSITION_BITS),
    .DEPTH_BITS    (DEPTH_BITS),
    .KEYWORD_BYTES (KEYWORD_BYTES)
  ) u_lexer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .item_i      (in_q),
    .tok_count_o (tok_n),
    .tok0_o      (tok0),
    .tok1_o      (tok1)
  );

  sbt_out_fifo u_out_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_n_i (tok_n),
    .push0_i  (tok0),
    .push1_i  (tok1),
    .pop_i    (!stall_i),
    .room_o   (room),
    .count_o  (count),
    .valid_o  (valid_o),
    .head_o   (data_o)
  );

  // queue never holds more than its four entries
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= 3'd4) else $error("result queue overflow");

  // the lexer only produces tokens on a step
  a_no_stray_tokens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step |-> tok_n == 2'd0) else $error("tokens without a step");

  // an end word always leaves at least the eof token queued
  a_eof_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && in_q.end_of_source |=> count != 3'd0) else $error("eof token lost");

  // the end word yields a final eof result
  a_eof_pushed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && in_q.end_of_source |-> tok_n != 2'd0) else $error("end word gave nothing");

endmodule

[dv/tb_source_byte_tokenizer_checker.sv]
// token checker for the source byte tokenizer: predicts tokens and compares them
`timescale 1ns / 1ps
module tb_source_byte_tokenizer_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  sbt_pkg::in_word_t  in_word_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  sbt_pkg::tok_word_t out_word_i,
  output int                 fail_count_o,
  output int                 tokens_waiting_o
);
  import sbt_pkg::*;

  localparam logic [15:0] DEPTH_TOP = 16'hFFFF;

  lex_mode_e   mode;
  logic [31:0] offset;
  logic [31:0] tok_begin;
  logic [7:0]  held_byte;
  logic [15:0] nest;
  logic [13:0][7:0] word_buf;
  int          word_len;
  logic        word_long;
  logic        escaped;

  tok_word_t   token_queue[$];
  tok_word_t   step_tokens[$];

  assign tokens_waiting_o = token_queue.size();

  function automatic logic [6:0] word_kind_of();
    logic [6:0] k;
    logic       hit;
    logic [111:0] t;
    int n;
    k = K_IDENT;
    if (!word_long) begin
      for (int i = 0; i < KwCount; i++) begin
        t = kw_text(i);
        n = 0;
        while (n < 14 && t[8*n +: 8] != 8'h00) n++;
        hit = (n == word_len);
        for (int j = 0; j < n && hit; j++)
          if (word_buf[j] != t[8*(n-1-j) +: 8]) hit = 1'b0;
        if (hit) k = K_KEY0 + 7'(i);
      end
    end
    return k;
  endfunction

  function automatic logic [6:0] lone_op(input logic [7:0] p);
    case (p)
      "-": return K_MINUS;
      "=": return K_ASSIGN;
      "!": return K_BANG;
      "<": return K_LT;
      ">": return K_GT;
      default: return K_INVALID;
    endcase
  endfunction

  function automatic logic [6:0] pair_op(input logic [7:0] p, input logic [7:0] b);
    if (p == "-" && b == ">") return K_ARROW;
    if (p == "=" && b == "=") return K_EQ;
    if (p == "=" && b == ">") return K_FATARROW;
    if (p == "!" && b == "=") return K_NE;
    if (p == "<" && b == "=") return K_LE;
    if (p == ">" && b == "=") return K_GE;
    if (p == "&" && b == "&") return K_ANDAND;
    if (p == "|" && b == "|") return K_OROR;
    return K_EOF;
  endfunction

  function automatic logic [6:0] one_byte_op(input logic [7:0] b);
    case (b)
      "(": return K_LPAREN;  ")": return K_RPAREN;  "{": return K_LBRACE;
      "}": return K_RBRACE;  "[": return K_LBRACK;  "]": return K_RBRACK;
      "+": return K_PLUS;    "*": return K_STAR;    "%": return K_PERCENT;
      ".": return K_DOT;     ",": return K_COMMA;   ":": return K_COLON;
      "@": return K_AT;      "?": return K_QUEST;
      default: return K_EOF;
    endcase
  endfunction

  function automatic logic letter(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic logic digit(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  task automatic push_token(input logic [6:0] k, input logic [31:0] s,
                            input logic [31:0] e, input logic [1:0] err);
    tok_word_t t;
    t.token_kind  = k;
    t.span_start  = s;
    t.span_end    = e;
    t.error_code  = err;
    t.last_of_run = 1'b0;
    step_tokens.push_back(t);
  endtask

  task automatic clear_lexer();
    mode = LEX_IDLE; offset = '0; tok_begin = '0; held_byte = '0; nest = '0;
    word_buf = '0; word_len = 0; word_long = 1'b0; escaped = 1'b0;
  endtask

  task automatic open_token(input logic [7:0] b, input logic [31:0] pos);
    logic [6:0] k;
    k = one_byte_op(b);
    tok_begin = pos;
    mode = LEX_IDLE;
    if (b == CH_SPACE || b == CH_TAB) mode = LEX_SPACE;
    else if (b == CH_LF) push_token(K_NEWLINE, pos, pos + 1, E_NONE);
    else if (b == CH_CR) mode = LEX_CR;
    else if (b == CH_UNDER || letter(b)) begin
      mode = LEX_IDENT; word_buf[0] = b; word_len = 1; word_long = 1'b0;
    end else if (digit(b)) mode = LEX_INT;
    else if (b == CH_QUOTE) begin
      mode = LEX_STRING; escaped = 1'b0;
    end else if (b == CH_SLASH) mode = LEX_SLASH;
    else if (k != K_EOF) push_token(k, pos, pos + 1, E_NONE);
    else if (is_op_lead(b)) begin
      mode = LEX_OP; held_byte = b;
    end else push_token(K_INVALID, pos, pos + 1, E_INVALID);
  endtask

  task automatic lex_byte(input logic [7:0] b);
    logic [31:0] pos, nxt, s;
    logic [6:0]  k;
    pos = offset; nxt = offset + 1; s = tok_begin;
    case (mode)
      LEX_SPACE:
        if (!(b == CH_SPACE || b == CH_TAB)) begin
          push_token(K_SPACE, s, pos, E_NONE); open_token(b, pos);
        end
      LEX_CR:
        if (b == CH_LF) begin
          push_token(K_NEWLINE, s, nxt, E_NONE); mode = LEX_IDLE;
        end else begin
          push_token(K_NEWLINE, s, pos, E_NONE); open_token(b, pos);
        end
      LEX_IDENT:
        if (b == CH_UNDER || letter(b) || digit(b)) begin
          if (word_len < 14) begin
            word_buf[word_len] = b; word_len++;
          end else word_long = 1'b1;
        end else begin
          push_token(word_kind_of(), s, pos, E_NONE); open_token(b, pos);
        end
      LEX_INT:
        if (!(digit(b) || b == CH_UNDER)) begin
          push_token(K_INT, s, pos, E_NONE); open_token(b, pos);
        end
      LEX_STRING:
        if (escaped) escaped = 1'b0;
        else if (b == CH_QUOTE) begin
          push_token(K_STRING, s, nxt, E_NONE); mode = LEX_IDLE;
        end else if (b == CH_LF || b == CH_CR) begin
          push_token(K_STRING, s, pos, E_STRING); open_token(b, pos);
        end else if (b == CH_BSLASH) escaped = 1'b1;
      LEX_SLASH:
        if (b == CH_SLASH) mode = LEX_LINE;
        else if (b == CH_STAR) begin
          mode = LEX_BLOCK; nest = 16'd1; held_byte = CH_NONE;
        end else begin
          push_token(K_SLASH, s, s + 1, E_NONE); open_token(b, pos);
        end
      LEX_LINE:
        if (b == CH_LF || b == CH_CR) begin
          push_token(K_LINE, s, pos, E_NONE); open_token(b, pos);
        end
      LEX_BLOCK:
        if (held_byte == CH_SLASH && b == CH_STAR) begin
          if (nest != DEPTH_TOP) nest++;
          held_byte = CH_NONE;
        end else if (held_byte == CH_STAR && b == CH_SLASH) begin
          held_byte = CH_NONE;
          if (nest != 0) nest--;
          if (nest == 0) begin
            push_token(K_BLOCK, s, nxt, E_NONE); mode = LEX_IDLE;
          end
        end else held_byte = (b == CH_SLASH || b == CH_STAR) ? b : CH_NONE;
      LEX_OP: begin
        k = pair_op(held_byte, b);
        if (k != K_EOF) begin
          push_token(k, s, nxt, E_NONE); mode = LEX_IDLE;
        end else begin
          k = lone_op(held_byte);
          push_token(k, s, s + 1, (k == K_INVALID) ? E_INVALID : E_NONE);
          open_token(b, pos);
        end
      end
      default: open_token(b, pos);
    endcase
    offset = nxt;
  endtask

  task automatic lex_end();
    logic [6:0] k;
    case (mode)
      LEX_SPACE:  push_token(K_SPACE, tok_begin, offset, E_NONE);
      LEX_CR:     push_token(K_NEWLINE, tok_begin, offset, E_NONE);
      LEX_IDENT:  push_token(word_kind_of(), tok_begin, offset, E_NONE);
      LEX_INT:    push_token(K_INT, tok_begin, offset, E_NONE);
      LEX_STRING: push_token(K_STRING, tok_begin, offset, E_STRING);
      LEX_SLASH:  push_token(K_SLASH, tok_begin, offset, E_NONE);
      LEX_LINE:   push_token(K_LINE, tok_begin, offset, E_NONE);
      LEX_BLOCK:  push_token(K_BLOCK, tok_begin, offset, E_BLOCK);
      LEX_OP: begin
        k = lone_op(held_byte);
        push_token(k, tok_begin, offset, (k == K_INVALID) ? E_INVALID : E_NONE);
      end
      default: ;
    endcase
    push_token(K_EOF, offset, offset, E_NONE);
    clear_lexer();
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    tok_word_t want;
    if (!rst_ni) begin
      clear_lexer();
      token_queue.delete();
      fail_count_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (token_queue.size() == 0) begin
          $display("%0t: unexpected token, expected none, actual %p", $time, out_word_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = token_queue.pop_front();
          if (want !== out_word_i) begin
            $display("%0t: token mismatch, expected %p, actual %p", $time, want, out_word_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        step_tokens.delete();
        if (in_word_i.end_of_source) lex_end();
        else lex_byte(in_word_i.data_byte);
        if (step_tokens.size() > 0) step_tokens[step_tokens.size()-1].last_of_run = 1'b1;
        foreach (step_tokens[i]) token_queue.push_back(step_tokens[i]);
      end
    end
  end
endmodule

[dv/tb_source_byte_tokenizer_top.sv]
// testbench top for the source byte tokenizer: clock, reset, stimulus, verdict
`timescale 1ns / 1ps
module tb_source_byte_tokenizer_top;
  import sbt_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int ITEMS       = 1650;
  localparam int TAIL_ITEMS  = 150;
  localparam int LONG_HOLD   = 300;
  localparam int FRAG_COUNT  = 24;

  logic      clk_i;
  logic      rst_ni;
  logic      valid_i;
  logic      stall_o;
  in_word_t  data_i;
  logic      valid_o;
  logic      stall_i;
  tok_word_t data_o;

  int fail_count;
  int tokens_waiting;
  int cycle_count = 0;
  int sent_count  = 0;
  int total_items = ITEMS;

  in_word_t stim[$];

  // source fragments covering every token class and the odd corners
  string frags [FRAG_COUNT] = '{
    "module ", "implementation", "capability ", "function(",
    "x_1 ", "123_4", "\"a\\\"b\" ", "\"open\n",
    "// note\015\n", "/* a /* b */ c */", "/*/ */", "->=>==!=<=>=&&||",
    "& | ! = < > -x", "a/b", "identifier_that_is_long ", " \t  ",
    "\015x", "{[()]}+*%.,:@?", "\"esc\\", "return if else match",
    "/* open", "#$`~", "_under9", "\015\n"
  };

  source_byte_tokenizer_top dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_i),
    .stall_o (stall_o),
    .data_i  (data_i),
    .valid_o (valid_o),
    .stall_i (stall_i),
    .data_o  (data_o)
  );

  tb_source_byte_tokenizer_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (valid_i),
    .in_stall_i       (stall_o),
    .in_word_i        (data_i),
    .out_valid_i      (valid_o),
    .out_stall_i      (stall_i),
    .out_word_i       (data_o),
    .fail_count_o     (fail_count),
    .tokens_waiting_o (tokens_waiting)
  );

  initial begin : clk_proc
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin : rst_proc
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // sender: builds the text, then offers words at falling edges
  initial begin : tx_proc
    in_word_t w;
    string    frag;
    int       pick;
    valid_i = 1'b0;
    data_i  = '0;
    while (stim.size() < ITEMS - 1) begin
      pick = $urandom_range(0, 31);
      w.end_of_source = 1'b0;
      if (pick < FRAG_COUNT) begin
        frag = frags[pick];
        for (int j = 0; j < frag.len(); j++) begin
          w.data_byte = frag[j];
          stim.push_back(w);
        end
      end else if (pick < 30) begin
        w.data_byte = 8'($urandom_range(0, 255));
        stim.push_back(w);
      end else begin
        w.data_byte = 8'($urandom_range(0, 255));
        w.end_of_source = 1'b1;
        stim.push_back(w);
      end
    end
    w.data_byte = 8'h00;
    w.end_of_source = 1'b1;
    stim.push_back(w);
    total_items = stim.size();

    @(posedge rst_ni);
    @(negedge clk_i);
    foreach (stim[i]) begin
      // wait for every expected token once, mid run
      if (i == (total_items * 3) / 4) begin
        valid_i = 1'b0;
        while (tokens_waiting != 0) @(negedge clk_i);
      end
      if (i < total_items - TAIL_ITEMS && $urandom_range(0, 7) == 0) begin
        valid_i = 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk_i);
      end
      valid_i = 1'b1;
      data_i  = stim[i];
      while (stall_o) @(negedge clk_i);
      @(negedge clk_i);
      sent_count++;
    end
    valid_i = 1'b0;
    while (tokens_waiting != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (fail_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  // receiver: random holds, one long hold, none near the end
  initial begin : rx_proc
    int hold;
    int long_done;
    stall_i   = 1'b0;
    long_done = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (sent_count >= total_items - TAIL_ITEMS) begin
        stall_i = 1'b0;
      end else if (long_done == 0 && sent_count >= total_items / 4) begin
        long_done = 1;
        stall_i   = 1'b1;
        hold      = 0;
        while (hold < LONG_HOLD) begin
          @(negedge clk_i);
          hold++;
        end
        stall_i = 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
        stall_i = 1'b1;
        repeat ($urandom_range(1, 13)) @(negedge clk_i);
        stall_i = 1'b0;
      end else begin
        stall_i = 1'b0;
      end
    end
  end

endmodule
